// ----- rtl/hsl_pkg.sv -----
// shared widths, types and the hue segment function for the hsl to rgb pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package hsl_pkg;

	localparam int unsigned CHANNEL_BITS = 8;

	// hue position held as six times the turn fraction, up to 6*ONE
	localparam int unsigned POS_W  = CHANNEL_BITS + 3;
	// curve factor runs from zero to ONE inclusive
	localparam int unsigned FAC_W  = CHANNEL_BITS + 1;
	// q, p and span carry unit 1/ONE^2 and stay at or below ONE^2
	localparam int unsigned WIDE_W = 2 * CHANNEL_BITS + 1;
	localparam int unsigned LS_W   = 2 * CHANNEL_BITS;
	localparam int unsigned ACC_W  = WIDE_W + FAC_W;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [FAC_W-1:0]        fac_t;
	typedef logic [WIDE_W-1:0]       wide_t;
	typedef logic [LS_W-1:0]         ls_t;
	typedef logic [ACC_W-1:0]        acc_t;

	localparam chan_t SAT_RESET = chan_t'(128);

	localparam pos_t POS_ONE   = pos_t'(2 ** CHANNEL_BITS);
	localparam pos_t POS_TWO   = pos_t'(2 * (2 ** CHANNEL_BITS));
	localparam pos_t POS_THREE = pos_t'(3 * (2 ** CHANNEL_BITS));
	localparam pos_t POS_FOUR  = pos_t'(4 * (2 ** CHANNEL_BITS));

	localparam fac_t FAC_ONE = fac_t'(2 ** CHANNEL_BITS);

	localparam acc_t ACC_HALF = acc_t'(1) << (2 * CHANNEL_BITS - 1);

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// weight of span for a wrapped hue position
	function automatic fac_t hue_factor(input pos_t t6);
		fac_t f;
		pos_t d;
		d = POS_FOUR - t6;
		if (t6 < POS_ONE) begin
			f = t6[FAC_W-1:0];
		end else if (t6 < POS_THREE) begin
			f = FAC_ONE;
		end else if (t6 < POS_FOUR) begin
			f = d[FAC_W-1:0];
		end else begin
			f = '0;
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/hsl_front.sv -----
// front stages: hue positions and l*s product, then q, p and span
// depends on hsl_pkg
`default_nettype none

module hsl_front import hsl_pkg::*; (
	input  wire logic     clk,
	input  wire pipe_en_t en,
	input  wire chan_t    hue,
	input  wire chan_t    lightness,
	input  wire chan_t    sat,
	output fac_t          fac_r_s2,
	output fac_t          fac_g_s2,
	output fac_t          fac_b_s2,
	output wide_t         p_s2,
	output wide_t         span_s2
);

	pos_t  hue6;
	pos_t  pos_r;
	pos_t  pos_b;
	fac_t  fac_r_s1;
	fac_t  fac_g_s1;
	fac_t  fac_b_s1;
	chan_t l_s1;
	chan_t s_s1;
	ls_t   ls_s1;
	wide_t l_one;
	wide_t s_one;
	wide_t ls_w;
	wide_t q;
	wide_t p;

	assign hue6 = pos_t'({hue, 2'b00}) + pos_t'({hue, 1'b0});
	// shift by a third of a turn either way, wrapping at a whole turn
	assign pos_r = (hue6 >= POS_FOUR) ? hue6 - POS_FOUR : hue6 + POS_TWO;
	assign pos_b = (hue6 >= POS_TWO) ? hue6 - POS_TWO : hue6 + POS_FOUR;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			fac_r_s1 <= hue_factor(pos_r);
			fac_g_s1 <= hue_factor(hue6);
			fac_b_s1 <= hue_factor(pos_b);
			l_s1     <= lightness;
			s_s1     <= sat;
			ls_s1    <= ls_t'(lightness) * ls_t'(sat);
		end
	end

	assign l_one = wide_t'({l_s1, {CHANNEL_BITS{1'b0}}});
	assign s_one = wide_t'({s_s1, {CHANNEL_BITS{1'b0}}});
	assign ls_w  = wide_t'(ls_s1);

	// lower half of lightness takes l*(1+s), upper half l+s-l*s
	assign q = l_s1[CHANNEL_BITS-1] ? (l_one + s_one - ls_w) : (l_one + ls_w);
	assign p = wide_t'({l_s1, {(CHANNEL_BITS + 1){1'b0}}}) - q;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			fac_r_s2 <= fac_r_s1;
			fac_g_s2 <= fac_g_s1;
			fac_b_s2 <= fac_b_s1;
			p_s2     <= p;
			span_s2  <= q - p;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hsl_chan.sv -----
// one colour channel: span times factor, then add p, round and saturate
// depends on hsl_pkg
`default_nettype none

module hsl_chan import hsl_pkg::*; (
	input  wire logic     clk,
	input  wire pipe_en_t en,
	input  wire fac_t     fac,
	input  wire wide_t    p,
	input  wire wide_t    span,
	output chan_t         chan_s4
);

	acc_t  prod_s3;
	wide_t p_s3;
	acc_t  acc;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= acc_t'(span) * acc_t'(fac);
			p_s3    <= p;
		end
	end

	// rounding to nearest, halves up
	assign acc = acc_t'({p_s3, {CHANNEL_BITS{1'b0}}}) + prod_s3 + ACC_HALF;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (|acc[ACC_W-1:3*CHANNEL_BITS]) begin
				chan_s4 <= '1;
			end else begin
				chan_s4 <= acc[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hsl_to_rgb_pixel_top.sv -----
// hsl to rgb pixel converter, four register stages
// throughput: one pixel per cycle while out_ready holds; each stage holds while the
// one after it is full and stalled, so bubbles are squeezed out before the input backs up
// reset clears the stage valid bits and sets saturation to 128
// depends on hsl_pkg, hsl_front and hsl_chan
`default_nettype none

module hsl_to_rgb_pixel_top import hsl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire chan_t hue_in,
	input  wire chan_t lightness_in,
	output logic       out_valid,
	input  wire logic  out_ready,
	output chan_t      red_out,
	output chan_t      green_out,
	output chan_t      blue_out,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire chan_t cfg_data
);

	chan_t    sat_q;
	logic     v_s1;
	logic     v_s2;
	logic     v_s3;
	logic     v_s4;
	pipe_en_t en;
	fac_t     fac_r;
	fac_t     fac_g;
	fac_t     fac_b;
	wide_t    p;
	wide_t    span;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= SAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sat_q <= cfg_data;
		end
	end

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en.s4 = !v_s4 || out_ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	hsl_front u_front (
		.clk       (clk),
		.en        (en),
		.hue       (hue_in),
		.lightness (lightness_in),
		.sat       (sat_q),
		.fac_r_s2  (fac_r),
		.fac_g_s2  (fac_g),
		.fac_b_s2  (fac_b),
		.p_s2      (p),
		.span_s2   (span)
	);

	hsl_chan u_red (
		.clk     (clk),
		.en      (en),
		.fac     (fac_r),
		.p       (p),
		.span    (span),
		.chan_s4 (red_out)
	);

	hsl_chan u_green (
		.clk     (clk),
		.en      (en),
		.fac     (fac_g),
		.p       (p),
		.span    (span),
		.chan_s4 (green_out)
	);

	hsl_chan u_blue (
		.clk     (clk),
		.en      (en),
		.fac     (fac_b),
		.p       (p),
		.span    (span),
		.chan_s4 (blue_out)
	);

	// input backs up only when every stage is full and the output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !(v_s1 && v_s2 && v_s3 && v_s4 && !out_ready))
		else $error("in_ready disagrees with pipeline occupancy");

	// an accepted input occupies the first stage on the next cycle
	a_in_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted input not held in first stage");

	// a stalled output keeps the third stage from advancing into it
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !out_ready && v_s3 |=> v_s3 && v_s4)
		else $error("pipeline item lost during output stall");

	// configuration transfer lands in the saturation register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> sat_q == $past(cfg_data))
		else $error("saturation register not written");

endmodule

`default_nettype wire
